[rtl/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal ASCII core.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } t_state;

endpackage

[rtl/signed_int_to_decimal_ascii_core.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Bit-serial double-dabble conversion of a signed integer to decimal ASCII.
// The '-' strobe for a negative input comes from the first conversion step; digits follow once every bit is shifted in.
// Busy for each request: one bit per cycle through the bcd shift register,
// then one bcd digit per cycle out of it.
// A new request is taken only once the core is back in idle after the last digit.
// Reset (synchronous, active low) returns to idle with no strobe; no receiver stall.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core
    import sitda_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          busy,
    output logic                          o_valid,
    output logic [7:0]                    o_char_code,
    output logic                          o_last_char
);

    localparam int NDIG   = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W  = 4 * NDIG;
    localparam int BCNT_W = $clog2(VALUE_WIDTH);
    localparam int DCNT_W = $clog2(NDIG + 1);

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic                   r_neg, n_neg;
    logic [BCNT_W-1:0]      r_bcnt, n_bcnt;
    logic [DCNT_W-1:0]      r_dcnt, n_dcnt;
    logic                   r_started, n_started;
    logic                   r_valid, n_valid;
    logic [7:0]             r_char, n_char;
    logic                   r_last, n_last;

    logic [VALUE_WIDTH-1:0] w_value_u;
    logic [BCD_W-1:0]       w_bcd_adj;
    logic [3:0]             w_top;
    logic                   w_last_dig;

    assign w_value_u  = $unsigned(i_value);
    assign w_top      = r_bcd[BCD_W-1 -: 4];
    assign w_last_dig = (r_dcnt == DCNT_W'(1));

    // add-3 correction per digit before each shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[4*i +: 4] >= BCD_ADJ_MIN) begin
                w_bcd_adj[4*i +: 4] = r_bcd[4*i +: 4] + BCD_ADJ;
            end else begin
                w_bcd_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_bcd     = r_bcd;
        n_neg     = r_neg;
        n_bcnt    = r_bcnt;
        n_dcnt    = r_dcnt;
        n_started = r_started;
        n_valid   = 1'b0;
        n_char    = r_char;
        n_last    = r_last;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_neg   = i_value[VALUE_WIDTH-1];
                    n_mag   = i_value[VALUE_WIDTH-1] ? (~w_value_u + VALUE_WIDTH'(1))
                                                     : w_value_u;
                    n_bcd   = '0;
                    n_bcnt  = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if ((r_bcnt == '0) && r_neg) begin
                    n_valid = 1'b1;
                    n_char  = CH_MINUS;
                    n_last  = 1'b0;
                end
                n_bcd  = {w_bcd_adj[BCD_W-2:0], r_mag[VALUE_WIDTH-1]};
                n_mag  = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                n_bcnt = r_bcnt + BCNT_W'(1);
                if (r_bcnt == BCNT_W'(VALUE_WIDTH - 1)) begin
                    n_dcnt    = DCNT_W'(NDIG);
                    n_started = 1'b0;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                // leading zeros are skipped, the units digit always goes out
                if (r_started || (w_top != 4'd0) || w_last_dig) begin
                    n_valid   = 1'b1;
                    n_char    = CH_ZERO + {4'd0, w_top};
                    n_last    = w_last_dig;
                    n_started = 1'b1;
                end
                n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                n_dcnt = r_dcnt - DCNT_W'(1);
                if (w_last_dig) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_bcd     <= n_bcd;
        r_neg     <= n_neg;
        r_bcnt    <= n_bcnt;
        r_dcnt    <= n_dcnt;
        r_started <= n_started;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request not taken");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_char |=> !o_valid)
        else $error("strobe after last character");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == CH_MINUS) ||
                    ((o_char_code >= CH_ZERO) && (o_char_code <= CH_ZERO + 8'd9)))
        else $error("character out of range");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_char_code == CH_MINUS) |-> !o_last_char)
        else $error("minus flagged last");

endmodule

[tb/sv/signed_int_to_decimal_ascii_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_test
// Sends signed 32-bit integers to the core and checks every character strobe
// against decimal text worked out here, most significant character first,
// with the last flag on the final character of each number. Directed
// extremes come first, then random values with random gaps between requests,
// then a closing run of back-to-back requests.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core_test;
    import sitda_pkg::*;

    localparam int WIDTH          = VALUE_WIDTH_DEF;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RANDOM_ITEMS   = 230;
    localparam int BURST_ITEMS    = 100;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start   = 1'b0;
    logic signed [WIDTH-1:0] i_value = '0;
    logic                    busy;
    logic                    o_valid;
    logic [7:0]              o_char_code;
    logic                    o_last_char;

    t_char expected_chars[$];
    int    error_count = 0;
    int    idle_cycles = 0;

    signed_int_to_decimal_ascii_core #(
        .VALUE_WIDTH(WIDTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_value    (i_value),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_char_code(o_char_code),
        .o_last_char(o_last_char)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_decimal_text(input logic [WIDTH-1:0] value);
        logic            negative;
        logic [WIDTH-1:0] magnitude;
        logic [3:0]      digits [20];
        int              ndig;
        t_char           entry;
        negative  = value[WIDTH-1];
        magnitude = negative ? (~value + 1'b1) : value;
        ndig      = 0;
        do begin
            digits[ndig] = 4'(magnitude % 10);
            ndig++;
            magnitude = magnitude / 10;
        end while (magnitude != 0);
        if (negative) begin
            entry.code = CH_MINUS;
            entry.last = 1'b0;
            expected_chars.push_back(entry);
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            entry.code = CH_ZERO + 8'(digits[i]);
            entry.last = (i == 0);
            expected_chars.push_back(entry);
        end
    endfunction

    // request capture and character check
    always @(posedge i_clk) begin
        t_char exp_char;
        if (i_rst_n && start && !busy) begin
            push_decimal_text(i_value);
        end
        if (i_rst_n && o_valid) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character: char_code %0d last_char %0d",
                       o_char_code, o_last_char);
                error_count++;
            end else begin
                exp_char = expected_chars.pop_front();
                if (o_char_code !== exp_char.code) begin
                    $error("char_code expected %0d actual %0d", exp_char.code, o_char_code);
                    error_count++;
                end
                if (o_last_char !== exp_char.last) begin
                    $error("last_char expected %0d actual %0d", exp_char.last, o_last_char);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || (i_rst_n && o_valid)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("signed_int_to_decimal_ascii_core_test: errors");
            $finish;
        end
    end

    task automatic send_request(input logic [WIDTH-1:0] value);
        start   <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // idle gap counted from the point where the core could take a request
    task automatic maybe_hold_off();
        int cycles;
        if ($urandom_range(0, 2) == 0) begin
            cycles = $urandom_range(1, 19);
            start   <= 1'b0;
            i_value <= $urandom;
            @(posedge i_clk);
            while (busy) @(posedge i_clk);
            repeat (cycles - 1) @(posedge i_clk);
        end
    endtask

    task automatic test_directed();
        logic [WIDTH-1:0] values [20] = '{
            32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
            32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
            32'd999999999, -32'sd1000000000, 32'd1234567890, -32'sd1234567890,
            32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_0000
        };
        foreach (values[i]) begin
            send_request(values[i]);
            maybe_hold_off();
        end
    endtask

    task automatic test_random_values();
        longint lo;
        longint hi;
        longint mag;
        int     ndig;
        logic   negative;
        logic [WIDTH-1:0] value;
        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                value = $urandom;
            end else begin
                ndig     = $urandom_range(1, 10);
                negative = 1'($urandom_range(0, 1));
                lo = 1;
                repeat (ndig - 1) lo = lo * 10;
                hi = lo * 10 - 1;
                if (ndig == 1) lo = 0;
                if (hi > 64'sd2147483647) hi = negative ? 64'sd2147483648 : 64'sd2147483647;
                mag   = lo + (longint'($urandom) % (hi - lo + 1));
                value = negative ? WIDTH'(-mag) : WIDTH'(mag);
            end
            send_request(value);
            maybe_hold_off();
        end
    endtask

    task automatic test_back_to_back();
        repeat (BURST_ITEMS) begin
            send_request($urandom);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_values();
        test_back_to_back();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("signed_int_to_decimal_ascii_core_test: clean");
        end else begin
            $display("signed_int_to_decimal_ascii_core_test: errors");
        end
        $finish;
    end

endmodule

[signed_int_to_decimal_ascii_core.f]
rtl/sitda_pkg.sv
rtl/signed_int_to_decimal_ascii_core.sv
tb/sv/signed_int_to_decimal_ascii_core_test.sv
